// ----- design/pmsa_pkg.sv -----
package pmsa_pkg;

    localparam int unsigned VOLT_W   = 15;
    localparam int unsigned CUR_W    = 16;
    localparam int unsigned PWR_W    = 16;
    localparam int unsigned VSUM_W   = 47;
    localparam int unsigned CSUM_W   = 48;
    localparam int unsigned PSUM_W   = 48;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned FLT_W    = 4;
    localparam int unsigned STAT_W   = 6;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 328;

    localparam int unsigned FLT_OVER_V  = 0;
    localparam int unsigned FLT_UNDER_V = 1;
    localparam int unsigned FLT_OVER_I  = 2;
    localparam int unsigned FLT_OVER_P  = 3;

    localparam logic [VOLT_W-1:0]        VMIN_RST = '1;
    localparam logic signed [CUR_W-1:0]  IMIN_RST = 16'sh7FFF;
    localparam logic [VSUM_W-1:0]        VSUM_MAX = '1;
    localparam logic signed [CSUM_W-1:0] CSUM_MAX = {1'b0, {(CSUM_W-1){1'b1}}};
    localparam logic signed [CSUM_W-1:0] CSUM_MIN = {1'b1, {(CSUM_W-1){1'b0}}};
    localparam logic [PSUM_W-1:0]        PSUM_MAX = '1;
    localparam logic [CNT_W-1:0]         CNT_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_OVER   = 2'd0,
        CFG_BUS_UNDER  = 2'd1,
        CFG_CUR_OVER   = 2'd2,
        CFG_PWR_OVER   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                     cmd;
        logic [VOLT_W-1:0]        bus_voltage;
        logic signed [CUR_W-1:0]  current_value;
        logic [PWR_W-1:0]         power_value;
        logic                     overflow_flag;
    } t_sample;

    typedef struct packed {
        logic [STAT_W-1:0]        status_flags;
        logic [VOLT_W-1:0]        vbus_min;
        logic [VOLT_W-1:0]        vbus_max;
        logic signed [CUR_W-1:0]  current_min;
        logic signed [CUR_W-1:0]  current_max;
        logic [PWR_W-1:0]         power_max;
        logic [VSUM_W-1:0]        vbus_total;
        logic signed [CSUM_W-1:0] current_total;
        logic [PSUM_W-1:0]        power_total;
        logic [CNT_W-1:0]         sample_total;
        logic [CNT_W-1:0]         overflow_total;
        logic [CNT_W-1:0]         alert_total;
    } t_stats;

endpackage

// ----- design/pmsa_in_reg.sv -----
module pmsa_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pmsa_pkg::t_sample  i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output pmsa_pkg::t_sample  o_sample
);

    logic              r_valid;
    pmsa_pkg::t_sample r_sample;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= i_sample;
        end
    end

endmodule

// ----- design/pmsa_limit_chk.sv -----
module pmsa_limit_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pmsa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pmsa_pkg::CFG_W-1:0]           i_cfg_data,
    input  pmsa_pkg::t_sample                    i_sample,
    output logic [pmsa_pkg::FLT_W-1:0]           o_fault
);

    logic [pmsa_pkg::VOLT_W-1:0] r_bus_over;
    logic [pmsa_pkg::VOLT_W-1:0] r_bus_under;
    logic [pmsa_pkg::CUR_W-2:0]  r_cur_over;
    logic [pmsa_pkg::PWR_W-1:0]  r_pwr_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_over  <= '0;
            r_bus_under <= '0;
            r_cur_over  <= '0;
            r_pwr_over  <= '0;
        end else if (i_cfg_we) begin
            unique case (pmsa_pkg::t_cfg_idx'(i_cfg_idx))
                pmsa_pkg::CFG_BUS_OVER:  r_bus_over  <= i_cfg_data[pmsa_pkg::VOLT_W-1:0];
                pmsa_pkg::CFG_BUS_UNDER: r_bus_under <= i_cfg_data[pmsa_pkg::VOLT_W-1:0];
                pmsa_pkg::CFG_CUR_OVER:  r_cur_over  <= i_cfg_data[pmsa_pkg::CUR_W-2:0];
                pmsa_pkg::CFG_PWR_OVER:  r_pwr_over  <= i_cfg_data[pmsa_pkg::PWR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_fault = '0;
        o_fault[pmsa_pkg::FLT_OVER_V]  = (r_bus_over != '0) &&
                                         (i_sample.bus_voltage > r_bus_over);
        o_fault[pmsa_pkg::FLT_UNDER_V] = (r_bus_under != '0) &&
                                         (i_sample.bus_voltage < r_bus_under);
        o_fault[pmsa_pkg::FLT_OVER_I]  = (r_cur_over != '0) &&
                                         (i_sample.current_value > $signed({1'b0, r_cur_over}));
        o_fault[pmsa_pkg::FLT_OVER_P]  = (r_pwr_over != '0) &&
                                         (i_sample.power_value > r_pwr_over);
    end

endmodule

// ----- design/pmsa_stats.sv -----
module pmsa_stats (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  pmsa_pkg::t_sample           i_sample,
    input  logic [pmsa_pkg::FLT_W-1:0]  i_fault,
    output logic                        o_valid,
    input  logic                        i_ready,
    output pmsa_pkg::t_stats            o_stats
);

    logic                                r_out_valid;
    logic                                r_fault_now;
    logic [pmsa_pkg::VOLT_W-1:0]         r_vmin, r_vmax;
    logic signed [pmsa_pkg::CUR_W-1:0]   r_imin, r_imax;
    logic [pmsa_pkg::PWR_W-1:0]          r_pmax;
    logic [pmsa_pkg::VSUM_W-1:0]         r_vsum;
    logic signed [pmsa_pkg::CSUM_W-1:0]  r_csum;
    logic [pmsa_pkg::PSUM_W-1:0]         r_psum;
    logic [pmsa_pkg::CNT_W-1:0]          r_samples, r_overflows, r_alerts;
    logic [pmsa_pkg::FLT_W-1:0]          r_sticky;
    logic                                r_halted;

    logic                                n_fault_now;
    logic [pmsa_pkg::VOLT_W-1:0]         n_vmin, n_vmax;
    logic signed [pmsa_pkg::CUR_W-1:0]   n_imin, n_imax;
    logic [pmsa_pkg::PWR_W-1:0]          n_pmax;
    logic [pmsa_pkg::VSUM_W-1:0]         n_vsum;
    logic signed [pmsa_pkg::CSUM_W-1:0]  n_csum;
    logic [pmsa_pkg::PSUM_W-1:0]         n_psum;
    logic [pmsa_pkg::CNT_W-1:0]          n_samples, n_overflows, n_alerts;
    logic [pmsa_pkg::FLT_W-1:0]          n_sticky;
    logic                                n_halted;

    logic [pmsa_pkg::VSUM_W:0]           vsum_ext;
    logic signed [pmsa_pkg::CSUM_W:0]    csum_ext;
    logic [pmsa_pkg::PSUM_W:0]           psum_ext;
    logic                                adv;

    assign o_ready = !r_out_valid || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_out_valid;

    assign vsum_ext = {1'b0, r_vsum} + (pmsa_pkg::VSUM_W+1)'(i_sample.bus_voltage);
    assign psum_ext = {1'b0, r_psum} + (pmsa_pkg::PSUM_W+1)'(i_sample.power_value);
    assign csum_ext = {r_csum[pmsa_pkg::CSUM_W-1], r_csum}
                    + {{(pmsa_pkg::CSUM_W+1-pmsa_pkg::CUR_W){i_sample.current_value[pmsa_pkg::CUR_W-1]}},
                       i_sample.current_value};

    always_comb begin
        n_fault_now = 1'b0;
        n_vmin      = r_vmin;
        n_vmax      = r_vmax;
        n_imin      = r_imin;
        n_imax      = r_imax;
        n_pmax      = r_pmax;
        n_vsum      = r_vsum;
        n_csum      = r_csum;
        n_psum      = r_psum;
        n_samples   = r_samples;
        n_overflows = r_overflows;
        n_alerts    = r_alerts;
        n_sticky    = r_sticky;
        n_halted    = r_halted;
        if (i_sample.cmd) begin
            n_vmin      = pmsa_pkg::VMIN_RST;
            n_vmax      = '0;
            n_imin      = pmsa_pkg::IMIN_RST;
            n_imax      = '0;
            n_pmax      = '0;
            n_vsum      = '0;
            n_csum      = '0;
            n_psum      = '0;
            n_samples   = '0;
            n_overflows = '0;
            n_alerts    = '0;
            n_sticky    = '0;
            n_halted    = 1'b0;
        end else if (!r_halted) begin
            if (i_sample.bus_voltage > r_vmax) n_vmax = i_sample.bus_voltage;
            if (i_sample.bus_voltage < r_vmin) n_vmin = i_sample.bus_voltage;
            if (i_sample.current_value > r_imax) n_imax = i_sample.current_value;
            if (i_sample.current_value < r_imin) n_imin = i_sample.current_value;
            if (i_sample.power_value > r_pmax) n_pmax = i_sample.power_value;
            n_vsum = vsum_ext[pmsa_pkg::VSUM_W] ? pmsa_pkg::VSUM_MAX
                                                : vsum_ext[pmsa_pkg::VSUM_W-1:0];
            n_psum = psum_ext[pmsa_pkg::PSUM_W] ? pmsa_pkg::PSUM_MAX
                                                : psum_ext[pmsa_pkg::PSUM_W-1:0];
            if (csum_ext[pmsa_pkg::CSUM_W] != csum_ext[pmsa_pkg::CSUM_W-1]) begin
                n_csum = csum_ext[pmsa_pkg::CSUM_W] ? pmsa_pkg::CSUM_MIN : pmsa_pkg::CSUM_MAX;
            end else begin
                n_csum = csum_ext[pmsa_pkg::CSUM_W-1:0];
            end
            if (r_samples != pmsa_pkg::CNT_MAX) n_samples = r_samples + 1'b1;
            if (i_sample.overflow_flag && (r_overflows != pmsa_pkg::CNT_MAX)) begin
                n_overflows = r_overflows + 1'b1;
            end
            if (i_fault != '0) begin
                n_sticky    = r_sticky | i_fault;
                n_halted    = 1'b1;
                n_fault_now = 1'b1;
                if (r_alerts != pmsa_pkg::CNT_MAX) n_alerts = r_alerts + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fault_now <= 1'b0;
            r_vmin      <= pmsa_pkg::VMIN_RST;
            r_vmax      <= '0;
            r_imin      <= pmsa_pkg::IMIN_RST;
            r_imax      <= '0;
            r_pmax      <= '0;
            r_vsum      <= '0;
            r_csum      <= '0;
            r_psum      <= '0;
            r_samples   <= '0;
            r_overflows <= '0;
            r_alerts    <= '0;
            r_sticky    <= '0;
            r_halted    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (adv) begin
                r_fault_now <= n_fault_now;
                r_vmin      <= n_vmin;
                r_vmax      <= n_vmax;
                r_imin      <= n_imin;
                r_imax      <= n_imax;
                r_pmax      <= n_pmax;
                r_vsum      <= n_vsum;
                r_csum      <= n_csum;
                r_psum      <= n_psum;
                r_samples   <= n_samples;
                r_overflows <= n_overflows;
                r_alerts    <= n_alerts;
                r_sticky    <= n_sticky;
                r_halted    <= n_halted;
            end
        end
    end

    always_comb begin
        o_stats.status_flags   = {r_halted, r_sticky, r_fault_now};
        o_stats.vbus_min       = r_vmin;
        o_stats.vbus_max       = r_vmax;
        o_stats.current_min    = r_imin;
        o_stats.current_max    = r_imax;
        o_stats.power_max      = r_pmax;
        o_stats.vbus_total     = r_vsum;
        o_stats.current_total  = r_csum;
        o_stats.power_total    = r_psum;
        o_stats.sample_total   = r_samples;
        o_stats.overflow_total = r_overflows;
        o_stats.alert_total    = r_alerts;
    end

    a_halt_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_sticky != '0))
        else $error("Halted without a sticky fault.");

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault_now |-> r_halted)
        else $error("Fault reported without halting.");

    a_alerts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alerts <= r_samples)
        else $error("Alert count exceeds sample count.");

    a_vbus_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_samples != '0) |-> (r_vmin <= r_vmax))
        else $error("Voltage minimum above maximum.");

    a_stall_holds_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_samples) && $stable(r_halted)
                                       && $stable(r_csum)))
        else $error("Statistics changed while a result was stalled.");

endmodule

// ----- design/power_monitor_stats_alert_unit.sv -----
// Power-monitor statistics and alert unit. Each input transaction is either a
// sample (tuser low) or a clear command (tuser high), and each one yields
// exactly one output transaction carrying the full statistics set after the
// update. A transaction is registered at the input stage, checked against the
// thresholds combinationally and then registered into the statistics stage,
// which presents the result. One transaction is taken per cycle while the
// output side keeps up; when it does not, both stages hold and the input
// stalls. A sample that trips an enabled threshold halts the unit; later
// samples are reported but leave the statistics untouched until a clear
// command arrives. Threshold registers are written through the configuration
// port by the user only while no transactions are in flight; the unit itself does not enforce this.
module power_monitor_stats_alert_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pmsa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pmsa_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: bus_voltage, current_value, power_value, overflow_flag.
    input  logic [pmsa_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // Fields from bit 0: cmd.
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: status_flags, vbus_min, vbus_max, current_min,
    // current_max, power_max, vbus_total, current_total, power_total,
    // sample_total, overflow_total, alert_total, then zero fill.
    output logic [pmsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    pmsa_pkg::t_sample               in_sample;
    pmsa_pkg::t_sample               reg_sample;
    pmsa_pkg::t_stats                stats;
    logic                            reg_valid;
    logic                            stats_ready;
    logic [pmsa_pkg::FLT_W-1:0]      fault;

    assign in_sample.cmd           = s_axis_tuser[0];
    assign in_sample.bus_voltage   = s_axis_tdata[14:0];
    assign in_sample.current_value = s_axis_tdata[30:15];
    assign in_sample.power_value   = s_axis_tdata[46:31];
    assign in_sample.overflow_flag = s_axis_tdata[47];

    pmsa_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (in_sample),
        .o_valid  (reg_valid),
        .i_ready  (stats_ready),
        .o_sample (reg_sample)
    );

    pmsa_limit_chk u_limit_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (reg_sample),
        .o_fault    (fault)
    );

    pmsa_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (reg_valid),
        .o_ready  (stats_ready),
        .i_sample (reg_sample),
        .i_fault  (fault),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_stats  (stats)
    );

    assign m_axis_tdata = {
        5'b0,
        stats.alert_total,
        stats.overflow_total,
        stats.sample_total,
        stats.power_total,
        stats.current_total,
        stats.vbus_total,
        stats.power_max,
        stats.current_max,
        stats.current_min,
        stats.vbus_max,
        stats.vbus_min,
        stats.status_flags
    };

endmodule
